// File: rtl/core/astm_pkg.sv
package astm_pkg;

   localparam int CMD_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW_SPAN   = 2'd0,
      CMD_WRITE_TEXEL = 2'd1,
      CMD_WRITE_SHADE = 2'd2,
      CMD_RESERVED    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      CSR_LOW_DETAIL = 2'd0,
      CSR_WINDOW_X   = 2'd1,
      CSR_WINDOW_Y   = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   localparam int COL_W       = 9;
   localparam int ROW_W       = 8;
   localparam int FIX_W       = 32;
   localparam int TILE_ADDR_W = 12;
   localparam int TILE_DEPTH  = 4096;
   localparam int SHADE_ADDR_W = 8;
   localparam int SHADE_DEPTH = 256;
   localparam int BYTE_W      = 8;
   localparam int LANES       = 8;
   localparam int LANE_W      = 3;
   localparam int BYTE_ADDR_W = 16;
   localparam int WORD_ADDR_W = 13;
   localparam int COUNT_W     = 9;
   localparam int SPAN_W      = 10;

   localparam logic [SPAN_W-1:0] SPAN_MAX_PIXELS = 10'd320;
   localparam logic [SPAN_W-1:0] SPAN_MAX_TEXELS = 10'd160;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_INDEX_W = 2;

endpackage

// File: rtl/core/astm_ram.sv
module astm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end

endmodule

// File: rtl/core/affine_span_texture_mapper.sv
// Affine floor span texture mapper.
// req channel: one transaction is one command. tuser carries the command
// (draw span, write texel, write shade entry); tdata carries the span and
// table fields. req_tready is high only while the block is idle.
// rsp channel: one transaction per frame buffer word touched by a span,
// tlast on the final word. Write commands and reversed spans give none.
// csr port: csr_we writes csr_wdata into register csr_index at once.
// A write command is written into its table as it is accepted. A draw
// command is accepted in idle, forms the start address in setup (one
// multiply), then issues one pixel per cycle, unless the output stalls,
// through the tile read and the shade read; low detail draws two
// pixels per texel. The chain tile memory -> shade memory -> word
// assembly sets the one pixel per cycle figure.
// A word waits in the output register while the next one is assembled;
// if the receiver stalls when another word completes, the whole pixel
// pipeline holds. Reset clears the state, csr, counter and valid
// registers and returns to idle; the texel tile and the shade table keep
// their contents and must be loaded before use.
module affine_span_texture_mapper #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // x_start[8:0] x_end[17:9] row[25:18] u_start[57:26] v_start[89:58]
   // u_step[121:90] v_step[153:122] table_index[165:154] table_value[173:166]
   input  logic [astm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[1:0]
   input  logic [astm_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_word[63:0] word_address[76:64] byte_mask[84:77]
   output logic [astm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [astm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [astm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW_W = $clog2(SCREEN_WIDTH + 1);
   localparam int LINE_W = astm_pkg::ROW_W + 1;
   localparam int PROD_W = LINE_W + SW_W;
   localparam int WORD_W = astm_pkg::LANES * astm_pkg::BYTE_W;

   astm_pkg::state_type state_ff, state_in;

   logic                               low_detail_ff, low_detail_in;
   logic [astm_pkg::COL_W-1:0]         window_x_ff, window_x_in;
   logic [astm_pkg::ROW_W-1:0]         window_y_ff, window_y_in;

   logic                               mode_ff, mode_in;
   logic [astm_pkg::FIX_W-1:0]         acc_u_ff, acc_u_in;
   logic [astm_pkg::FIX_W-1:0]         acc_v_ff, acc_v_in;
   logic [astm_pkg::FIX_W-1:0]         step_u_ff, step_u_in;
   logic [astm_pkg::FIX_W-1:0]         step_v_ff, step_v_in;
   logic [astm_pkg::ROW_W-1:0]         row_ff, row_in;
   logic [astm_pkg::SPAN_W-1:0]        col_ff, col_in;
   logic [astm_pkg::COUNT_W-1:0]       count_ff, count_in;

   logic [astm_pkg::COUNT_W-1:0]       rem0_ff, rem0_in;
   logic [astm_pkg::COUNT_W-1:0]       rem2_ff, rem2_in;
   logic                               phase_ff, phase_in;
   logic [astm_pkg::TILE_ADDR_W-1:0]   idx_hold_ff, idx_hold_in;
   logic                               s1_valid_ff, s1_valid_in;
   logic                               s2_valid_ff, s2_valid_in;

   logic [astm_pkg::LANE_W-1:0]        slot_ff, slot_in;
   logic [astm_pkg::LANES*astm_pkg::BYTE_W-1:0] word_ff, word_in;
   logic [astm_pkg::LANES-1:0]         mask_ff, mask_in;
   logic [astm_pkg::WORD_ADDR_W-1:0]   waddr_ff, waddr_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [astm_pkg::LANES*astm_pkg::BYTE_W-1:0] rsp_word_ff, rsp_word_in;
   logic [astm_pkg::WORD_ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [astm_pkg::LANES-1:0]         rsp_mask_ff, rsp_mask_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [astm_pkg::COL_W-1:0]         f_x_start, f_x_end;
   logic [astm_pkg::ROW_W-1:0]         f_row;
   logic [astm_pkg::FIX_W-1:0]         f_u_start, f_v_start, f_u_step, f_v_step;
   logic [astm_pkg::TILE_ADDR_W-1:0]   f_table_index;
   logic [astm_pkg::BYTE_W-1:0]        f_table_value;
   astm_pkg::command_type              f_command;

   logic                               accept;
   logic [astm_pkg::SPAN_W-1:0]        span_len, texels;
   logic                               reversed;
   logic [LINE_W-1:0]                  line;
   logic [PROD_W-1:0]                  prod;
   logic [astm_pkg::BYTE_ADDR_W-1:0]   base;

   logic                               stall, advance, issue;
   logic [astm_pkg::TILE_ADDR_W-1:0]   idx_now, tile_addr;
   logic [astm_pkg::FIX_W-1:0]         add_a, add_b, add_sum;
   logic                               word_done, final_pixel, consume;
   logic [astm_pkg::LANES*astm_pkg::BYTE_W-1:0] word_next;
   logic [astm_pkg::LANES-1:0]         mask_next;

   logic                               tile_we, shade_we;
   logic [astm_pkg::SHADE_ADDR_W-1:0]  shade_addr;
   logic [astm_pkg::BYTE_W-1:0]        tile_rdata, shade_rdata;

   assign f_x_start     = req_tdata[8:0];
   assign f_x_end       = req_tdata[17:9];
   assign f_row         = req_tdata[25:18];
   assign f_u_start     = req_tdata[57:26];
   assign f_v_start     = req_tdata[89:58];
   assign f_u_step      = req_tdata[121:90];
   assign f_v_step      = req_tdata[153:122];
   assign f_table_index = req_tdata[165:154];
   assign f_table_value = req_tdata[173:166];
   assign f_command     = astm_pkg::command_type'(req_tuser);

   assign req_tready = (state_ff == astm_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign reversed = (f_x_end < f_x_start);
   assign span_len = {1'b0, f_x_end} - {1'b0, f_x_start} + astm_pkg::SPAN_W'(1);
   assign texels   = (span_len > astm_pkg::SPAN_MAX_TEXELS) ?
                     astm_pkg::SPAN_MAX_TEXELS : span_len;

   assign line = {1'b0, window_y_ff} + {1'b0, row_ff};
   assign prod = PROD_W'(line) * PROD_W'(SCREEN_WIDTH);
   assign base = astm_pkg::BYTE_ADDR_W'(prod) + astm_pkg::BYTE_ADDR_W'(window_x_ff)
               + astm_pkg::BYTE_ADDR_W'(col_ff);

   assign final_pixel = (rem2_ff == astm_pkg::COUNT_W'(1));
   assign word_done   = (slot_ff == astm_pkg::LANE_W'(astm_pkg::LANES - 1)) || final_pixel;
   assign stall       = s2_valid_ff && word_done && rsp_valid_ff && !rsp_tready;
   assign advance     = !stall;
   assign issue       = (state_ff == astm_pkg::ST_RUN) && (rem0_ff != '0) && advance;
   assign consume     = s2_valid_ff && advance;

   always_comb begin
      if (mode_ff) begin
         idx_now = {acc_v_ff[21:16], acc_u_ff[21:16]};
      end else begin
         idx_now = {acc_u_ff[15:10], acc_u_ff[31:26]};
      end
      tile_addr = (mode_ff && phase_ff) ? idx_hold_ff : idx_now;
      if (mode_ff && phase_ff) begin
         add_a = acc_v_ff;
         add_b = step_v_ff;
      end else begin
         add_a = acc_u_ff;
         add_b = step_u_ff;
      end
      add_sum = add_a + add_b;
   end

   assign word_next = word_ff | (WORD_W'(shade_rdata) << {slot_ff, 3'b000});
   assign mask_next = mask_ff | (astm_pkg::LANES'(1) << slot_ff);

   assign tile_we  = accept && (f_command == astm_pkg::CMD_WRITE_TEXEL);
   assign shade_we = accept && (f_command == astm_pkg::CMD_WRITE_SHADE);
   assign shade_addr = shade_we ? f_table_index[astm_pkg::SHADE_ADDR_W-1:0] : tile_rdata;

   astm_ram #(
      .WIDTH (astm_pkg::BYTE_W),
      .DEPTH (astm_pkg::TILE_DEPTH)
   ) u_tile_ram (
      .clock (clock),
      .en    (tile_we || advance),
      .we    (tile_we),
      .addr  (tile_we ? f_table_index : tile_addr),
      .wdata (f_table_value),
      .rdata (tile_rdata)
   );

   astm_ram #(
      .WIDTH (astm_pkg::BYTE_W),
      .DEPTH (astm_pkg::SHADE_DEPTH)
   ) u_shade_ram (
      .clock (clock),
      .en    (shade_we || advance),
      .we    (shade_we),
      .addr  (shade_addr),
      .wdata (f_table_value),
      .rdata (shade_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      low_detail_in = low_detail_ff;
      window_x_in   = window_x_ff;
      window_y_in   = window_y_ff;
      mode_in       = mode_ff;
      acc_u_in      = acc_u_ff;
      acc_v_in      = acc_v_ff;
      step_u_in     = step_u_ff;
      step_v_in     = step_v_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      count_in      = count_ff;
      rem0_in       = rem0_ff;
      rem2_in       = rem2_ff;
      phase_in      = phase_ff;
      idx_hold_in   = idx_hold_ff;
      s1_valid_in   = s1_valid_ff;
      s2_valid_in   = s2_valid_ff;
      slot_in       = slot_ff;
      word_in       = word_ff;
      mask_in       = mask_ff;
      waddr_in      = waddr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         unique case (astm_pkg::csr_index_type'(csr_index))
            astm_pkg::CSR_LOW_DETAIL: low_detail_in = csr_wdata[0];
            astm_pkg::CSR_WINDOW_X:   window_x_in   = csr_wdata;
            astm_pkg::CSR_WINDOW_Y:   window_y_in   = csr_wdata[astm_pkg::ROW_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         astm_pkg::ST_IDLE: begin
            if (accept && (f_command == astm_pkg::CMD_DRAW_SPAN) && !reversed) begin
               state_in  = astm_pkg::ST_SETUP;
               mode_in   = low_detail_ff;
               row_in    = f_row;
               acc_v_in  = f_v_start;
               step_v_in = f_v_step;
               if (low_detail_ff) begin
                  acc_u_in  = f_u_start;
                  step_u_in = f_u_step;
                  col_in    = {f_x_start, 1'b0};
                  count_in  = astm_pkg::COUNT_W'({texels, 1'b0});
               end else begin
                  acc_u_in  = {f_u_start[21:6], f_v_start[21:6]};
                  step_u_in = {f_u_step[21:6], f_v_step[21:6]};
                  col_in    = {1'b0, f_x_start};
                  count_in  = (span_len > astm_pkg::SPAN_MAX_PIXELS) ?
                              astm_pkg::COUNT_W'(astm_pkg::SPAN_MAX_PIXELS) :
                              astm_pkg::COUNT_W'(span_len);
               end
            end
         end
         astm_pkg::ST_SETUP: begin
            state_in = astm_pkg::ST_RUN;
            slot_in  = base[astm_pkg::LANE_W-1:0];
            waddr_in = base[astm_pkg::BYTE_ADDR_W-1:astm_pkg::LANE_W];
            word_in  = '0;
            mask_in  = '0;
            rem0_in  = count_ff;
            rem2_in  = count_ff;
            phase_in = 1'b0;
         end
         astm_pkg::ST_RUN: begin
            if (consume && final_pixel) begin
               state_in = astm_pkg::ST_IDLE;
            end
         end
         default: state_in = astm_pkg::ST_IDLE;
      endcase

      if (advance) begin
         s1_valid_in = issue;
         s2_valid_in = s1_valid_ff;
      end

      if (issue) begin
         rem0_in = rem0_ff - astm_pkg::COUNT_W'(1);
         if (mode_ff) begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_v_in = add_sum;
            end else begin
               acc_u_in    = add_sum;
               idx_hold_in = idx_now;
            end
         end else begin
            acc_u_in = add_sum;
         end
      end

      if (consume) begin
         rem2_in = rem2_ff - astm_pkg::COUNT_W'(1);
         slot_in = slot_ff + astm_pkg::LANE_W'(1);
         if (word_done) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = word_next;
            rsp_mask_in  = mask_next;
            rsp_addr_in  = waddr_ff;
            rsp_last_in  = final_pixel;
            word_in      = '0;
            mask_in      = '0;
            waddr_in     = waddr_ff + astm_pkg::WORD_ADDR_W'(1);
         end else begin
            word_in = word_next;
            mask_in = mask_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= astm_pkg::ST_IDLE;
         low_detail_ff <= 1'b0;
         window_x_ff   <= '0;
         window_y_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rem0_ff       <= '0;
         rem2_ff       <= '0;
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         low_detail_ff <= low_detail_in;
         window_x_ff   <= window_x_in;
         window_y_ff   <= window_y_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rem0_ff       <= rem0_in;
         rem2_ff       <= rem2_in;
         phase_ff      <= phase_in;
      end
      mode_ff     <= mode_in;
      acc_u_ff    <= acc_u_in;
      acc_v_ff    <= acc_v_in;
      step_u_ff   <= step_u_in;
      step_v_ff   <= step_v_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      count_ff    <= count_in;
      idx_hold_ff <= idx_hold_in;
      slot_ff     <= slot_in;
      word_ff     <= word_in;
      mask_ff     <= mask_in;
      waddr_ff    <= waddr_in;
      rsp_word_ff <= rsp_word_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_mask_ff, rsp_addr_ff, rsp_word_ff};

endmodule

// File: tb/affine_span_texture_mapper_checker.sv
module affine_span_texture_mapper_checker #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // x_start, x_end, row, u_start, v_start, u_step, v_step, table_index, table_value
   input  logic [astm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic [astm_pkg::CMD_W-1:0]       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_word, word_address, byte_mask
   input  logic [astm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [astm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [astm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               outstanding,
   output int                               words_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0]                      pixel_word;
      logic [astm_pkg::WORD_ADDR_W-1:0] word_address;
      logic [7:0]                       byte_mask;
      logic                             last;
   } span_word_type;

   logic [7:0]                 tile_mem  [astm_pkg::TILE_DEPTH];
   logic [7:0]                 shade_mem [astm_pkg::SHADE_DEPTH];
   logic                       low_mode = 1'b0;
   logic [astm_pkg::COL_W-1:0] win_x    = '0;
   logic [astm_pkg::ROW_W-1:0] win_y    = '0;

   span_word_type span_words_due[$];
   int            mismatches = 0;
   int            due_count  = 0;
   int            word_total = 0;

   assign fail_count    = mismatches;
   assign outstanding   = due_count;
   assign words_checked = word_total;

   task automatic render_span(input logic [8:0] xs, input logic [8:0] xe,
                              input logic [7:0] row, input logic [31:0] us,
                              input logic [31:0] vs, input logic [31:0] ud,
                              input logic [31:0] vd);
      logic [7:0]    pix       [320];
      logic [63:0]   word_data [41];
      logic [7:0]    word_mask [41];
      logic [31:0]   u_acc, v_acc, pos, stp;
      logic [11:0]   texel_idx;
      int unsigned   count, n, col, base, off, nwords, p;
      span_word_type w;
      n = 0;
      count = xe - xs + 1;
      if (low_mode) begin
         if (count > 160) count = 160;
         u_acc = us;
         v_acc = vs;
         for (int i = 0; i < count; i++) begin
            texel_idx = {v_acc[21:16], u_acc[21:16]};
            pix[n] = shade_mem[tile_mem[texel_idx]];
            pix[n+1] = pix[n];
            n = n + 2;
            u_acc = u_acc + ud;
            v_acc = v_acc + vd;
         end
         col = {xs, 1'b0};
      end else begin
         if (count > 320) count = 320;
         pos = {us[21:6], vs[21:6]};
         stp = {ud[21:6], vd[21:6]};
         for (int i = 0; i < count; i++) begin
            texel_idx = {pos[15:10], pos[31:26]};
            pix[n] = shade_mem[tile_mem[texel_idx]];
            n = n + 1;
            pos = pos + stp;
         end
         col = xs;
      end
      base = ((win_y + row) * SCREEN_WIDTH + win_x + col) & 32'hffff;
      off = base & 7;
      nwords = (off + n - 1) / 8 + 1;
      for (int i = 0; i < 41; i++) begin
         word_data[i] = '0;
         word_mask[i] = '0;
      end
      for (int i = 0; i < n; i++) begin
         p = off + i;
         word_data[p/8][8*(p%8) +: 8] = pix[i];
         word_mask[p/8][p%8] = 1'b1;
      end
      for (int i = 0; i < nwords; i++) begin
         w.pixel_word   = word_data[i];
         w.word_address = astm_pkg::WORD_ADDR_W'((base >> 3) + i);
         w.byte_mask    = word_mask[i];
         w.last         = (i == nwords - 1);
         span_words_due.push_back(w);
      end
   endtask

   always @(posedge clock) begin : watch
      span_word_type         exp_w;
      astm_pkg::command_type req_cmd;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               astm_pkg::CSR_LOW_DETAIL: low_mode = csr_wdata[0];
               astm_pkg::CSR_WINDOW_X:   win_x = csr_wdata[astm_pkg::COL_W-1:0];
               astm_pkg::CSR_WINDOW_Y:   win_y = csr_wdata[astm_pkg::ROW_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            req_cmd = astm_pkg::command_type'(req_tuser);
            case (req_cmd)
               astm_pkg::CMD_WRITE_TEXEL:
                  tile_mem[req_tdata[165:154]] = req_tdata[173:166];
               astm_pkg::CMD_WRITE_SHADE:
                  shade_mem[req_tdata[161:154]] = req_tdata[173:166];
               astm_pkg::CMD_DRAW_SPAN: begin
                  if (req_tdata[17:9] >= req_tdata[8:0])
                     render_span(req_tdata[8:0], req_tdata[17:9], req_tdata[25:18],
                                 req_tdata[57:26], req_tdata[89:58],
                                 req_tdata[121:90], req_tdata[153:122]);
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (span_words_due.size() == 0) begin
               $error("unexpected rsp transaction: pixel_word %h word_address %0d byte_mask %b",
                      rsp_tdata[63:0], rsp_tdata[76:64], rsp_tdata[84:77]);
               mismatches++;
            end else begin
               exp_w = span_words_due.pop_front();
               word_total++;
               if (exp_w.pixel_word !== rsp_tdata[63:0]) begin
                  $error("pixel_word: expected %h, actual %h", exp_w.pixel_word,
                         rsp_tdata[63:0]);
                  mismatches++;
               end
               if (exp_w.word_address !== rsp_tdata[76:64]) begin
                  $error("word_address: expected %0d, actual %0d", exp_w.word_address,
                         rsp_tdata[76:64]);
                  mismatches++;
               end
               if (exp_w.byte_mask !== rsp_tdata[84:77]) begin
                  $error("byte_mask: expected %b, actual %b", exp_w.byte_mask,
                         rsp_tdata[84:77]);
                  mismatches++;
               end
               if (exp_w.last !== rsp_tlast) begin
                  $error("last: expected %b, actual %b", exp_w.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         due_count <= span_words_due.size();
      end
   end

endmodule

// File: tb/affine_span_texture_mapper_tb.sv
module affine_span_texture_mapper_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_WIDTH  = 320;
   localparam int CYCLE_LIMIT   = 20_000_000;
   localparam int SETTLE_CYCLES = 24;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [astm_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [astm_pkg::CMD_W-1:0]       req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b1;
   logic [astm_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_we     = 1'b0;
   logic [astm_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [astm_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   int   fail_count;
   int   outstanding;
   int   words_checked;
   logic calm        = 1'b0;
   int   stall_left  = 0;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   spans_sent  = 0;
   int   settings    = 0;

   affine_span_texture_mapper #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   affine_span_texture_mapper_checker #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d words still due", cycle_count, outstanding);
         $display("affine_span_texture_mapper_tb: FAIL");
         $finish;
      end
   end

   task automatic send_item(astm_pkg::command_type cmd, logic [8:0] xs, logic [8:0] xe,
                            logic [7:0] row, logic [31:0] us, logic [31:0] vs,
                            logic [31:0] ud, logic [31:0] vd, logic [11:0] tidx,
                            logic [7:0] tval);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, tval, tidx, vd, ud, vs, us, row, xe, xs};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_write(astm_pkg::command_type cmd, logic [11:0] idx,
                             logic [7:0] val);
      send_item(cmd, 9'($urandom_range(0, 319)), 9'($urandom_range(0, 319)),
                8'($urandom_range(0, 199)), $urandom, $urandom, $urandom, $urandom,
                idx, val);
   endtask

   task automatic send_span(logic [8:0] xs, logic [8:0] xe, logic [7:0] row,
                            logic [31:0] us, logic [31:0] vs, logic [31:0] ud,
                            logic [31:0] vd);
      send_item(astm_pkg::CMD_DRAW_SPAN, xs, xe, row, us, vs, ud, vd,
                12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
      spans_sent++;
   endtask

   // drain every due word, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic configure(logic low, logic [8:0] wx, logic [7:0] wy);
      settle();
      csr_we    <= 1'b1;
      csr_index <= astm_pkg::CSR_LOW_DETAIL;
      csr_wdata <= {8'd0, low};
      @(posedge clock);
      csr_index <= astm_pkg::CSR_WINDOW_X;
      csr_wdata <= wx;
      @(posedge clock);
      csr_index <= astm_pkg::CSR_WINDOW_Y;
      csr_wdata <= {1'b0, wy};
      @(posedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   function automatic logic [31:0] pick_step();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($urandom_range(0, 32'h3ffff)) - 32'h1ffff;
   endfunction

   task automatic random_span();
      logic [8:0] xs, xe;
      int         len;
      case ($urandom_range(0, 9))
         0: begin
            xs = 9'($urandom_range(1, 319));
            xe = 9'($urandom_range(0, xs - 1));
         end
         1: begin
            xs = 9'($urandom_range(0, 319));
            xe = 9'($urandom_range(xs, 319));
         end
         default: begin
            len = $urandom_range(0, 15);
            xs = 9'($urandom_range(0, 319 - len));
            xe = xs + 9'(len);
         end
      endcase
      send_span(xs, xe, 8'($urandom_range(0, 199)), $urandom, $urandom,
                pick_step(), pick_step());
   endtask

   task automatic run_random(int count, logic final_part);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         if (final_part) calm = 1'b1;
         else if (sent % 25 == 0) calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_item(astm_pkg::CMD_RESERVED, 9'($urandom_range(0, 319)),
                      9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)),
                      $urandom, $urandom, $urandom, $urandom,
                      12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
         end else begin
            if (pick <= 5)
               send_write(astm_pkg::CMD_WRITE_TEXEL, 12'($urandom_range(0, 4095)),
                          8'($urandom_range(0, 255)));
            else if (pick <= 8)
               send_write(astm_pkg::CMD_WRITE_SHADE, 12'($urandom_range(0, 4095)),
                          8'($urandom_range(0, 255)));
            else
               random_span();
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      configure(1'b0, 9'd0, 8'd0);

      // fill both stores so no span reads an unwritten entry
      for (int i = 0; i < astm_pkg::TILE_DEPTH; i++)
         send_write(astm_pkg::CMD_WRITE_TEXEL, 12'(i), 8'($urandom_range(0, 255)));
      for (int i = 0; i < astm_pkg::SHADE_DEPTH; i++)
         send_write(astm_pkg::CMD_WRITE_SHADE, 12'(i + 256 * $urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));

      send_write(astm_pkg::CMD_WRITE_TEXEL, 12'd4095, 8'd255);
      send_write(astm_pkg::CMD_WRITE_TEXEL, 12'd0, 8'd0);
      send_write(astm_pkg::CMD_WRITE_SHADE, 12'd4095, 8'd0);
      send_span(9'd0, 9'd319, 8'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      send_span(9'd319, 9'd319, 8'd199, $urandom, $urandom, $urandom, $urandom);
      send_span(9'd0, 9'd0, 8'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
      send_span(9'd10, 9'd9, 8'd5, $urandom, $urandom, $urandom, $urandom);
      send_span(9'd319, 9'd0, 8'd199, $urandom, $urandom, $urandom, $urandom);
      send_span(9'd3, 9'd40, 8'd17, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                32'h7fff_ffff);
      // v field overflows on every step after the first and carries into u
      send_span(9'd5, 9'd30, 8'd60, 32'd0, 32'd0, 32'd0, 32'h003f_ffc0);
      send_span(9'd100, 9'd131, 8'd100, 32'h0020_0000, 32'h0, -32'sd32768, 32'h0001_8000);
      send_item(astm_pkg::CMD_RESERVED, 9'd0, 9'd319, 8'd0, $urandom, $urandom, $urandom,
                $urandom, 12'd4095, 8'd255);

      configure(1'b1, 9'd319, 8'd199);
      send_span(9'd0, 9'd319, 8'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);
      send_span(9'd159, 9'd159, 8'd10, $urandom, $urandom, $urandom, $urandom);
      send_span(9'd1, 9'd0, 8'd10, $urandom, $urandom, $urandom, $urandom);
      send_span(9'd20, 9'd60, 8'd199, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'hffff_ffff);
      send_span(9'd100, 9'd319, 8'd199, $urandom, $urandom, pick_step(), pick_step());
      send_span(9'd319, 9'd319, 8'd0, $urandom, $urandom, $urandom, $urandom);

      configure(1'b0, 9'd319, 8'd199);
      send_span(9'd0, 9'd319, 8'd199, $urandom, $urandom, pick_step(), pick_step());
      send_span(9'd7, 9'd8, 8'd3, $urandom, $urandom, $urandom, $urandom);

      configure(1'b0, 9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
      run_random(90, 1'b0);
      configure(1'b1, 9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
      run_random(90, 1'b0);
      configure(1'b0, 9'd0, 8'd0);
      run_random(80, 1'b0);
      configure(1'b1, 9'd319, 8'd0);
      run_random(80, 1'b0);
      calm = 1'b1;
      configure(1'($urandom_range(0, 1)), 9'($urandom_range(0, 319)),
                8'($urandom_range(0, 199)));
      run_random(90, 1'b1);
      settle();

      $display("covered %0d req transactions (%0d spans) over %0d register settings",
               items_sent, spans_sent, settings);
      $display("compared %0d rsp words, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0) begin
         $display("affine_span_texture_mapper_tb: PASS");
      end else begin
         $display("affine_span_texture_mapper_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/astm_pkg.sv
rtl/core/astm_ram.sv
rtl/core/affine_span_texture_mapper.sv
tb/affine_span_texture_mapper_checker.sv
tb/affine_span_texture_mapper_tb.sv
